[hdl/ptds_pkg.sv]
package ptds_pkg;

  // field widths fixed by the interface
  localparam int TIME_W = 32;
  localparam int ID_W   = 8;
  localparam int KIND_W = 3;
  localparam int CMD_W  = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [TIME_W-1:0] time_t;

  // command codes
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_REG   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  // result kinds
  localparam kind_t KIND_FIRED   = 3'd0;
  localparam kind_t KIND_UPDATED = 3'd1;
  localparam kind_t KIND_ADDED   = 3'd2;
  localparam kind_t KIND_FULL    = 3'd3;
  localparam kind_t KIND_CLEARED = 3'd4;

endpackage

[hdl/periodic_task_due_scheduler.sv]
// channel | direction | handshake           | payload
// in_     | input     | in_valid/in_ready   | command, now_time, task_id, period, enable
// out_    | output    | out_valid/out_ready | kind, task_key, lateness, last
// cfg_    | input     | cfg_wr_en           | cfg_wr_data (priority mode)
//
// A tick walks the slots through S_READ and S_EVAL, adds S_CMP for an enabled slot and S_PUSH
// for a firing, and stops after the first firing when priority mode is on; a register searches
// the slots through S_READ and S_EVAL and then updates a match, appends or reports a full table;
// a clear goes straight to S_FLUSH. One shared 33-bit subtractor.
// rst_n is synchronous and empties the table; slot contents stay undefined until written.
// in_ready is high only while idle; a result waiting on out_ready holds the sequencer.
module periodic_task_due_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int KEY_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptds_pkg::CMD_W-1:0]    in_command,
  input  logic [ptds_pkg::TIME_W-1:0]   in_now_time,
  input  logic [ptds_pkg::ID_W-1:0]     in_task_id,
  input  logic [ptds_pkg::TIME_W-1:0]   in_period,
  input  logic                          in_enable,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptds_pkg::KIND_W-1:0]   out_kind,
  output logic [ptds_pkg::ID_W-1:0]     out_task_key,
  output logic [ptds_pkg::TIME_W-1:0]   out_lateness,
  output logic                          out_last
);

  localparam int KW    = (KEY_BITS < ptds_pkg::ID_W) ? KEY_BITS : ptds_pkg::ID_W;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TW    = ptds_pkg::TIME_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  // slot table
  logic [KW-1:0] key_mem    [MAX_TASKS];
  logic [TW-1:0] period_mem [MAX_TASKS];
  logic          en_mem     [MAX_TASKS];
  logic [TW-1:0] last_mem   [MAX_TASKS];

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   prio_r;
  ptds_pkg::cmd_t         cmd_r, cmd_nxt;
  logic [TW-1:0]          now_r, now_nxt;
  logic [KW-1:0]          key_r, key_nxt;
  logic [TW-1:0]          period_r, period_nxt;
  logic                   en_r, en_nxt;
  logic [TW-1:0]          elapsed_r, elapsed_nxt;

  // pending result, held until it is known whether another follows
  logic                   pend_valid_r, pend_valid_nxt;
  ptds_pkg::kind_t        pend_kind_r, pend_kind_nxt;
  logic [KW-1:0]          pend_key_r, pend_key_nxt;
  logic [TW-1:0]          pend_late_r, pend_late_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  ptds_pkg::kind_t        out_kind_r, out_kind_nxt;
  logic [KW-1:0]          out_key_r, out_key_nxt;
  logic [TW-1:0]          out_late_r, out_late_nxt;
  logic                   out_last_r, out_last_nxt;

  // registered read port
  logic [KW-1:0]          rd_key_r;
  logic [TW-1:0]          rd_period_r;
  logic                   rd_en_r;
  logic [TW-1:0]          rd_last_r;

  // write port controls
  logic                   wr_cfg;
  logic                   wr_last;
  logic [TW-1:0]          wr_last_data;
  logic [IDX_W-1:0]       addr;

  // shared subtractor
  logic [TW-1:0]          sub_a, sub_b;
  logic [TW:0]            sub_res;
  logic                   sub_borrow;

  logic                   in_xfer;
  logic                   out_free;
  logic                   out_load;
  logic                   at_end;
  logic                   table_full;

  assign addr       = idx_r[IDX_W-1:0];
  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign at_end     = (idx_r == cnt_r);
  assign table_full = (cnt_r == CNT_W'(MAX_TASKS));

  // operand select: elapsed time first, then elapsed minus period
  always_comb begin
    if (state_r == S_CMP) begin
      sub_a = elapsed_r;
      sub_b = rd_period_r;
    end else begin
      sub_a = now_r;
      sub_b = rd_last_r;
    end
  end
  assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_res[TW];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    now_nxt        = now_r;
    key_nxt        = key_r;
    period_nxt     = period_r;
    en_nxt         = en_r;
    elapsed_nxt    = elapsed_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt  = pend_kind_r;
    pend_key_nxt   = pend_key_r;
    pend_late_nxt  = pend_late_r;
    out_load       = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_key_nxt    = out_key_r;
    out_late_nxt   = out_late_r;
    out_last_nxt   = out_last_r;
    wr_cfg         = 1'b0;
    wr_last        = 1'b0;
    wr_last_data   = now_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = in_command;
          now_nxt        = in_now_time;
          key_nxt        = in_task_id[KW-1:0];
          period_nxt     = in_period;
          en_nxt         = in_enable;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          if (in_command == ptds_pkg::CMD_TICK || in_command == ptds_pkg::CMD_REG) begin
            state_nxt = S_READ;
          end else if (in_command == ptds_pkg::CMD_CLEAR) begin
            cnt_nxt        = '0;
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = ptds_pkg::KIND_CLEARED;
            pend_key_nxt   = '0;
            pend_late_nxt  = '0;
            state_nxt      = S_FLUSH;
          end
        end
      end

      S_READ: begin
        if (at_end) begin
          if (cmd_r == ptds_pkg::CMD_TICK) begin
            state_nxt = pend_valid_r ? S_FLUSH : S_IDLE;
          end else begin
            // no matching key: append or report full
            pend_valid_nxt = 1'b1;
            pend_key_nxt   = key_r;
            pend_late_nxt  = '0;
            if (table_full) begin
              pend_kind_nxt = ptds_pkg::KIND_FULL;
            end else begin
              pend_kind_nxt = ptds_pkg::KIND_ADDED;
              wr_cfg        = 1'b1;
              wr_last       = 1'b1;
              wr_last_data  = '0;
              cnt_nxt       = CNT_W'(cnt_r + 1'b1);
            end
            state_nxt = S_FLUSH;
          end
        end else begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (cmd_r == ptds_pkg::CMD_REG) begin
          if (rd_key_r == key_r) begin
            wr_cfg         = 1'b1;
            pend_valid_nxt = 1'b1;
            pend_kind_nxt  = ptds_pkg::KIND_UPDATED;
            pend_key_nxt   = key_r;
            pend_late_nxt  = '0;
            state_nxt      = S_FLUSH;
          end else begin
            idx_nxt   = CNT_W'(idx_r + 1'b1);
            state_nxt = S_READ;
          end
        end else if (rd_en_r) begin
          elapsed_nxt = sub_res[TW-1:0];
          state_nxt   = S_CMP;
        end else begin
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          state_nxt = S_READ;
        end
      end

      S_CMP: begin
        if (sub_borrow) begin
          idx_nxt   = CNT_W'(idx_r + 1'b1);
          state_nxt = S_READ;
        end else begin
          // due: stamp the slot and keep the lateness
          wr_last     = 1'b1;
          elapsed_nxt = sub_res[TW-1:0];
          state_nxt   = S_PUSH;
        end
      end

      S_PUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_load     = 1'b1;
            out_kind_nxt = pend_kind_r;
            out_key_nxt  = pend_key_r;
            out_late_nxt = pend_late_r;
            out_last_nxt = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_kind_nxt  = ptds_pkg::KIND_FIRED;
          pend_key_nxt   = rd_key_r;
          pend_late_nxt  = elapsed_r;
          idx_nxt        = CNT_W'(idx_r + 1'b1);
          state_nxt      = prio_r ? S_FLUSH : S_READ;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_nxt   = pend_kind_r;
          out_key_nxt    = pend_key_r;
          out_late_nxt   = pend_late_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      prio_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        prio_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    now_r       <= now_nxt;
    key_r       <= key_nxt;
    period_r    <= period_nxt;
    en_r        <= en_nxt;
    elapsed_r   <= elapsed_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_key_r  <= pend_key_nxt;
    pend_late_r <= pend_late_nxt;
    out_kind_r  <= out_kind_nxt;
    out_key_r   <= out_key_nxt;
    out_late_r  <= out_late_nxt;
    out_last_r  <= out_last_nxt;
  end

  // slot table write and registered read
  always_ff @(posedge clk) begin
    if (wr_cfg) begin
      key_mem[addr]    <= key_r;
      period_mem[addr] <= period_r;
      en_mem[addr]     <= en_r;
    end
    if (wr_last) begin
      last_mem[addr] <= wr_last_data;
    end
    rd_key_r    <= key_mem[addr];
    rd_period_r <= period_mem[addr];
    rd_en_r     <= en_mem[addr];
    rd_last_r   <= last_mem[addr];
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_task_key = ptds_pkg::ID_W'(out_key_r);
  assign out_lateness = out_late_r;
  assign out_last     = out_last_r;

  // table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TASKS))
    else $error("slot count beyond table depth");

  // the walk index never runs past the slot count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r <= cnt_r))
    else $error("walk index past slot count");

  // nothing is left pending when a new item may enter
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_valid_r)
    else $error("pending result while idle");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(out_kind_r) && $stable(out_late_r)))
    else $error("waiting result overwritten");

  // a clear empties the table on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_command == ptds_pkg::CMD_CLEAR) |=> (cnt_r == '0))
    else $error("clear did not empty the table");

endmodule

[tb/tb_periodic_task_due_scheduler.sv]
module tb_periodic_task_due_scheduler;

  typedef logic [ptds_pkg::ID_W-1:0] task_id_t;

  localparam int             MAX_SLOTS     = 16;
  localparam int             SETTLE_CYCLES = 100;
  localparam int             CYCLE_LIMIT   = 400000;
  localparam ptds_pkg::cmd_t CMD_UNKNOWN   = 2'd3;

  typedef struct {
    ptds_pkg::kind_t kind;
    task_id_t        key;
    ptds_pkg::time_t lateness;
    logic            last;
  } sched_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_wr_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ptds_pkg::cmd_t    in_command = ptds_pkg::CMD_TICK;
  ptds_pkg::time_t   in_now_time = '0;
  task_id_t          in_task_id = '0;
  ptds_pkg::time_t   in_period = '0;
  logic              in_enable = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ptds_pkg::kind_t   out_kind;
  task_id_t          out_task_key;
  ptds_pkg::time_t   out_lateness;
  logic              out_last;

  // shadow task table and scan mode
  task_id_t        task_key_tbl [MAX_SLOTS];
  ptds_pkg::time_t period_tbl   [MAX_SLOTS];
  logic            enabled_tbl  [MAX_SLOTS];
  ptds_pkg::time_t fired_at_tbl [MAX_SLOTS];
  int              tasks_in_table = 0;
  logic            priority_scan = 1'b0;

  sched_result_t   due_results[$];
  ptds_pkg::time_t ms_clock = '0;
  logic            quiet = 1'b0;
  int              error_count = 0;
  int              items_sent = 0;
  int              results_seen = 0;
  int              fired_total = 0;
  int              mode_writes = 0;

  periodic_task_due_scheduler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_now_time (in_now_time),
    .in_task_id  (in_task_id),
    .in_period   (in_period),
    .in_enable   (in_enable),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_task_key(out_task_key),
    .out_lateness(out_lateness),
    .out_last    (out_last)
  );

  always #2 clk = ~clk;

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 6);
  end

  // expected results for one accepted command, applied to the shadow table
  function automatic void schedule_step(ptds_pkg::cmd_t cmd, ptds_pkg::time_t now,
                                        task_id_t id, ptds_pkg::time_t per, logic en);
    sched_result_t   batch[$];
    sched_result_t   r;
    ptds_pkg::time_t elapsed;
    int              hit;
    hit = -1;
    r.lateness = '0;
    r.last = 1'b0;
    case (cmd)
      ptds_pkg::CMD_TICK: begin
        for (int i = 0; i < tasks_in_table; i++) begin
          if (enabled_tbl[i]) begin
            elapsed = now - fired_at_tbl[i];
            if (elapsed >= period_tbl[i]) begin
              r.kind = ptds_pkg::KIND_FIRED;
              r.key = task_key_tbl[i];
              r.lateness = elapsed - period_tbl[i];
              batch.push_back(r);
              fired_at_tbl[i] = now;
              fired_total++;
              if (priority_scan) break;
            end
          end
        end
      end
      ptds_pkg::CMD_REG: begin
        for (int i = 0; i < tasks_in_table; i++) begin
          if (hit < 0 && task_key_tbl[i] == id) hit = i;
        end
        r.key = id;
        if (hit >= 0) begin
          period_tbl[hit] = per;
          enabled_tbl[hit] = en;
          r.kind = ptds_pkg::KIND_UPDATED;
        end else if (tasks_in_table >= MAX_SLOTS) begin
          r.kind = ptds_pkg::KIND_FULL;
        end else begin
          task_key_tbl[tasks_in_table] = id;
          period_tbl[tasks_in_table] = per;
          enabled_tbl[tasks_in_table] = en;
          fired_at_tbl[tasks_in_table] = '0;
          tasks_in_table++;
          r.kind = ptds_pkg::KIND_ADDED;
        end
        batch.push_back(r);
      end
      ptds_pkg::CMD_CLEAR: begin
        tasks_in_table = 0;
        r.kind = ptds_pkg::KIND_CLEARED;
        r.key = '0;
        batch.push_back(r);
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endfunction

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kind %0d key %0d lateness %0d last %0d",
                 $time, out_kind, out_task_key, out_lateness, out_last);
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind || out_task_key !== want.key ||
            out_lateness !== want.lateness || out_last !== want.last) begin
          error_count++;
          $display("%0t: mismatch expected kind %0d key %0d lateness %0d last %0d,",
                   $time, want.kind, want.key, want.lateness, want.last);
          $display("%0t:   got kind %0d key %0d lateness %0d last %0d",
                   $time, out_kind, out_task_key, out_lateness, out_last);
        end
      end
    end
  end

  // one command transfer, with an occasional gap ahead of it
  task automatic send_item(input ptds_pkg::cmd_t cmd, input ptds_pkg::time_t now,
                           input task_id_t id, input ptds_pkg::time_t per, input logic en);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 6) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_now_time <= now;
    in_task_id  <= id;
    in_period   <= per;
    in_enable   <= en;
    do @(posedge clk); while (!in_ready);
    schedule_step(cmd, now, id, per, en);
    if (cmd != CMD_UNKNOWN) items_sent++;
  endtask

  // stop sending and let every pending result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_priority(input logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    priority_scan = mode;
    mode_writes++;
  endtask

  // add, update, fire at time extremes and wraparound, silent tick, unknown command
  task automatic test_basic_ops();
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'd0, 32'd0, 1'b1);
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'd255, 32'hFFFF_FFFF, 1'b1);
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'h5A, 32'd10, 1'b0);
    send_item(ptds_pkg::CMD_TICK, 32'd0, task_id_t'($urandom()), $urandom(), 1'b0);
    send_item(ptds_pkg::CMD_TICK, 32'hFFFF_FFFF, task_id_t'($urandom()), $urandom(), 1'b1);
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'h5A, 32'd5, 1'b1);
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'd0, 32'd0, 1'b0);
    send_item(ptds_pkg::CMD_TICK, 32'd3, task_id_t'($urandom()), $urandom(), 1'b1);
    send_item(CMD_UNKNOWN, $urandom(), task_id_t'($urandom()), $urandom(), 1'b1);
  endtask

  // fill every slot, then one rejected key and one update while full
  task automatic test_full_table();
    for (int k = 1; k <= 13; k++)
      send_item(ptds_pkg::CMD_REG, $urandom(), task_id_t'(k), ptds_pkg::time_t'(k), 1'b1);
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'd200, 32'd1, 1'b1);
    send_item(ptds_pkg::CMD_REG, $urandom(), 8'd7, 32'd0, 1'b1);
  endtask

  // scan stops at the first firing, then the table is emptied
  task automatic test_priority_scan();
    wait_idle();
    set_priority(1'b1);
    send_item(ptds_pkg::CMD_TICK, 32'd100, task_id_t'($urandom()), $urandom(), 1'b0);
    send_item(ptds_pkg::CMD_TICK, 32'd100, task_id_t'($urandom()), $urandom(), 1'b0);
    send_item(ptds_pkg::CMD_CLEAR, $urandom(), task_id_t'($urandom()), $urandom(), 1'b1);
  endtask

  task automatic random_item();
    int              pick;
    ptds_pkg::cmd_t  cmd;
    ptds_pkg::time_t now;
    task_id_t        id;
    ptds_pkg::time_t per;
    int              r;
    pick = $urandom_range(0, 99);
    if (pick < 50) cmd = ptds_pkg::CMD_TICK;
    else if (pick < 95) cmd = ptds_pkg::CMD_REG;
    else if (pick < 97) cmd = ptds_pkg::CMD_CLEAR;
    else cmd = CMD_UNKNOWN;
    // time mostly advances a little, sometimes jumps anywhere
    if (cmd == ptds_pkg::CMD_TICK) begin
      if ($urandom_range(0, 9) < 8) ms_clock = ms_clock + $urandom_range(0, 12);
      else ms_clock = $urandom();
      now = ms_clock;
    end else begin
      now = $urandom();
    end
    // small key pool so updates and a full table happen
    id = ($urandom_range(0, 99) < 85) ? task_id_t'($urandom_range(0, 21))
                                      : task_id_t'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 7) per = $urandom_range(0, 15);
    else if (r < 9) per = $urandom_range(0, 300);
    else per = $urandom();
    send_item(cmd, now, id, per, $urandom_range(0, 4) != 0);
  endtask

  task automatic test_random_phase(input logic mode, input logic calm, input int count);
    int target;
    wait_idle();
    set_priority(mode);
    quiet <= calm;
    target = items_sent + count;
    while (items_sent < target) random_item();
    wait_idle();
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_priority(1'b0);
    test_basic_ops();
    test_full_table();
    test_priority_scan();
    test_random_phase(1'b0, 1'b0, 49);
    test_random_phase(1'b1, 1'b0, 49);
    test_random_phase(1'b0, 1'b1, 49);
    test_random_phase(1'b1, 1'b0, 49);
    wait_idle();
    $display("covered %0d commands over %0d scan-mode writes:", items_sent, mode_writes);
    $display("%0d results checked, %0d firings", results_seen, fired_total);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("periodic_task_due_scheduler verification clean");
    end else begin
      $display("%0d errors, %0d results outstanding", error_count, due_results.size());
      $display("periodic_task_due_scheduler verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("periodic_task_due_scheduler verification failed");
    $finish;
  end

endmodule
